// File: sv/ftl_pkg.sv
// ftl_pkg: shared types and constants for the flat trie prefix lookup
// no dependencies
package ftl_pkg;
    localparam logic [1:0] MODE_BODY  = 2'd0;
    localparam logic [1:0] MODE_INDEX = 2'd1;
    localparam logic [1:0] MODE_LOOK  = 2'd2;

    // one beat carried from the front part to the back part
    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] addr;
        logic [15:0] ch;
        logic [11:0] next_skip;
        logic        has_child;
        logic        ends_word;
        logic [31:0] info_in;
        logic        last_char;
    } t_beat;
endpackage

// File: sv/ftl_queue.sv
// ftl_queue: two-entry beat queue between the front and the back part
// depends on ftl_pkg
module ftl_queue
    import ftl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_beat i_beat,
    output logic  o_valid,
    input  logic  i_ready,
    output t_beat o_beat
);
    t_beat       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        w_push;
    logic        w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_beat  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_beat;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// File: sv/ftl_walk.sv
// ftl_walk: back part, body and index memories, index search and sibling walk
// depends on ftl_pkg
module ftl_walk
    import ftl_pkg::*;
#(
    parameter int BODY_DEPTH  = 4096,
    parameter int INDEX_DEPTH = 256,
    parameter int MAX_WORD    = 32,
    parameter int SKIP_BITS   = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [8:0]  i_index_entries,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_beat       i_beat,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_prefix_len,
    output logic [5:0]  o_matched_chars,
    output logic [31:0] o_info_out,
    output logic        o_pos_valid,
    output logic [11:0] o_last_pos,
    output logic [5:0]  o_word_len
);
    localparam int BW = $clog2(BODY_DEPTH);
    localparam int IW = $clog2(INDEX_DEPTH);
    localparam int SW = (IW + 1 > 9) ? IW + 1 : 9;
    localparam int PW = 21;
    localparam int CW = $clog2(MAX_WORD + 1);
    localparam logic [SKIP_BITS-1:0] SKIP_NONE = '1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SRD  = 3'd1;
    localparam logic [2:0] ST_SCMP = 3'd2;
    localparam logic [2:0] ST_BRD  = 3'd3;
    localparam logic [2:0] ST_BCMP = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    typedef struct packed {
        logic [15:0]          ch;
        logic [SKIP_BITS-1:0] skip;
        logic                 child;
        logic                 ends;
        logic [31:0]          info;
    } t_body;

    t_body       r_body [BODY_DEPTH];
    logic [27:0] r_index [INDEX_DEPTH];
    t_body       r_brd;
    logic [27:0] r_ird;

    logic [2:0]    r_st;
    t_beat         r_cur;
    logic [PW-1:0] r_pos;
    logic          r_alive;
    logic          r_start;
    logic [CW-1:0] r_match;
    logic [CW-1:0] r_best;
    logic [31:0]   r_binfo;
    logic          r_lvalid;
    logic [11:0]   r_lpos;
    logic [CW-1:0] r_chars;
    logic [SW-1:0] r_lo;
    logic [SW-1:0] r_hi;
    logic          r_ovalid;

    logic [SW-1:0] w_hi0;
    logic [SW-1:0] w_mid;
    logic [PW-1:0] w_next;
    logic          w_out_load;

    assign o_ready = (r_st == ST_IDLE);
    assign w_hi0 = ({{(SW-9){1'b0}}, i_index_entries} > SW'(INDEX_DEPTH))
                   ? SW'(INDEX_DEPTH) : {{(SW-9){1'b0}}, i_index_entries};
    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_next = r_pos + PW'(r_brd.skip);
    // result register loads when the word ends and the slot is free
    assign w_out_load = (r_st == ST_DONE) && r_cur.last_char && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_beat.mode == MODE_BODY
            && 32'(i_beat.addr) < BODY_DEPTH) begin
            r_body[i_beat.addr[BW-1:0]] <= {i_beat.ch, i_beat.next_skip[SKIP_BITS-1:0],
                i_beat.has_child, i_beat.ends_word, i_beat.info_in};
        end
        if (i_valid && o_ready && i_beat.mode == MODE_INDEX
            && 32'(i_beat.addr) < INDEX_DEPTH) begin
            r_index[i_beat.addr[IW-1:0]] <= {i_beat.ch, i_beat.next_skip};
        end
        r_brd <= r_body[r_pos[BW-1:0]];
        r_ird <= r_index[w_mid[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_alive  <= 1'b0;
            r_start  <= 1'b1;
            r_match  <= '0;
            r_best   <= '0;
            r_binfo  <= '0;
            r_lvalid <= 1'b0;
            r_lpos   <= '0;
            r_chars  <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_valid && i_beat.mode == MODE_LOOK) begin
                        r_cur <= i_beat;
                        if (r_start) begin
                            r_start  <= 1'b0;
                            r_match  <= '0;
                            r_best   <= '0;
                            r_binfo  <= '0;
                            r_lvalid <= 1'b0;
                            r_lpos   <= '0;
                            r_chars  <= '0;
                            r_alive  <= 1'b0;
                            r_lo     <= '0;
                            r_hi     <= w_hi0;
                            r_st     <= ST_SRD;
                        end else begin
                            r_st <= ST_BRD;
                        end
                    end
                end
                ST_SRD: begin
                    // index read of the midpoint in flight
                    r_st <= (r_lo < r_hi) ? ST_SCMP : ST_BRD;
                end
                ST_SCMP: begin
                    if (r_ird[27:12] == r_cur.ch) begin
                        r_alive <= 1'b1;
                        r_pos   <= PW'(r_ird[11:0]);
                        r_st    <= ST_BRD;
                    end else begin
                        if (r_cur.ch > r_ird[27:12]) r_lo <= w_mid + 1'b1;
                        else r_hi <= w_mid;
                        r_st <= ST_SRD;
                    end
                end
                ST_BRD: begin
                    if (r_chars >= CW'(MAX_WORD)) begin
                        r_st <= ST_DONE;
                    end else if (!r_alive || 32'(r_pos) >= BODY_DEPTH) begin
                        r_alive <= 1'b0;
                        r_chars <= r_chars + 1'b1;
                        r_st    <= ST_DONE;
                    end else begin
                        r_st <= ST_BCMP;
                    end
                end
                ST_BCMP: begin
                    if (r_cur.ch == r_brd.ch) begin
                        r_match  <= r_match + 1'b1;
                        r_lvalid <= 1'b1;
                        r_lpos   <= 12'(r_pos);
                        if (r_brd.ends) begin
                            r_best  <= r_match + 1'b1;
                            r_binfo <= r_brd.info;
                        end
                        if (r_brd.child) r_pos <= r_pos + 1'b1;
                        else r_alive <= 1'b0;
                        r_chars <= r_chars + 1'b1;
                        r_st    <= ST_DONE;
                    end else if (r_cur.ch > r_brd.ch && r_brd.skip != SKIP_NONE
                                 && r_brd.skip != '0) begin
                        r_pos <= w_next;
                        r_st  <= ST_BRD;
                    end else begin
                        r_alive <= 1'b0;
                        r_chars <= r_chars + 1'b1;
                        r_st    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_cur.last_char) begin
                        r_st <= ST_IDLE;
                    end else if (w_out_load) begin
                        o_prefix_len    <= 6'(r_best);
                        o_matched_chars <= 6'(r_match);
                        o_info_out      <= r_binfo;
                        o_pos_valid     <= r_lvalid;
                        o_last_pos      <= r_lvalid ? r_lpos : 12'd0;
                        o_word_len      <= 6'(r_chars);
                        r_start         <= 1'b1;
                        r_alive         <= 1'b0;
                        r_st            <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
endmodule

// File: sv/flat_trie_longest_prefix_lookup.sv
// flat_trie_longest_prefix_lookup: top level, front queue and back walker
// depends on ftl_pkg, ftl_queue, ftl_walk
//
// channel | direction | signals
// input   | in        | i_valid / o_ready, mode addr ch next_skip flags info last_char
// result  | out       | o_valid / i_ready, prefix_len matched_chars info pos_valid pos len
// config  | in        | i_cfg_we / i_cfg_data (index_entries)
//
// load beats are written while the walker is idle; a lookup character takes an index
// read and compare per search step, a body read and compare per entry visited, then
// done; a missed search adds an index read; a dead walk or an over-long word skips the
// body compare; beats are registered in the queue before the walker sees them; the
// body read port of the walker sets the pace; reset is synchronous, no memory
// clearing; the queue absorbs input while a result waits on i_ready
module flat_trie_longest_prefix_lookup
    import ftl_pkg::*;
#(
    parameter int BODY_DEPTH  = 4096,
    parameter int INDEX_DEPTH = 256,
    parameter int MAX_WORD    = 32,
    parameter int SKIP_BITS   = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_addr,
    input  logic [15:0] i_ch,
    input  logic [11:0] i_next_skip,
    input  logic        i_has_child,
    input  logic        i_ends_word,
    input  logic [31:0] i_info_in,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_prefix_len,
    output logic [5:0]  o_matched_chars,
    output logic [31:0] o_info_out,
    output logic        o_pos_valid,
    output logic [11:0] o_last_pos,
    output logic [5:0]  o_word_len
);
    logic [8:0] r_entries;
    t_beat      w_in;
    t_beat      w_q;
    logic       w_qv;
    logic       w_qr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_entries <= '0;
        else if (i_cfg_we) r_entries <= i_cfg_data;
    end

    assign w_in = '{mode: i_mode, addr: i_addr, ch: i_ch, next_skip: i_next_skip,
                    has_child: i_has_child, ends_word: i_ends_word,
                    info_in: i_info_in, last_char: i_last_char};

    ftl_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_beat(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_beat(w_q)
    );

    ftl_walk #(
        .BODY_DEPTH(BODY_DEPTH), .INDEX_DEPTH(INDEX_DEPTH),
        .MAX_WORD(MAX_WORD), .SKIP_BITS(SKIP_BITS)
    ) u_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_index_entries(r_entries),
        .i_valid(w_qv), .o_ready(w_qr), .i_beat(w_q),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_prefix_len(o_prefix_len), .o_matched_chars(o_matched_chars),
        .o_info_out(o_info_out), .o_pos_valid(o_pos_valid),
        .o_last_pos(o_last_pos), .o_word_len(o_word_len)
    );
endmodule

// File: sv/ftl_checker.sv
// ftl_checker: port-level assertions for the prefix lookup
// binds to flat_trie_longest_prefix_lookup
module ftl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [5:0]  o_prefix_len,
    input logic [5:0]  o_matched_chars,
    input logic        o_pos_valid,
    input logic [11:0] o_last_pos,
    input logic [5:0]  o_word_len
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word_len))
        else $error("result beat dropped or changed");
    a_pref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_prefix_len <= o_matched_chars)
        else $error("prefix longer than match");
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_matched_chars <= o_word_len)
        else $error("match longer than word");
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pos_valid |-> o_last_pos == 12'd0 && o_matched_chars == 6'd0)
        else $error("position without match");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule

bind flat_trie_longest_prefix_lookup ftl_checker u_ftl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_prefix_len(o_prefix_len), .o_matched_chars(o_matched_chars),
    .o_pos_valid(o_pos_valid), .o_last_pos(o_last_pos), .o_word_len(o_word_len)
);
